// ===== rtl/vrra_pkg.sv =====
`default_nettype none

package vrra_pkg;

    localparam int CMD_W  = 2;
    localparam int VIEW_W = 4;
    localparam int ROW_W  = 7;
    localparam int CNT_W  = 16;

    typedef enum logic [CMD_W-1:0] {
        CMD_OCCUPY = 2'd0,
        CMD_FREE   = 2'd1,
        CMD_FIND   = 2'd2,
        CMD_CLEAR  = 2'd3
    } t_cmd;

    localparam logic signed [CNT_W-1:0] CNT_MAX = {1'b0, {(CNT_W-1){1'b1}}};
    localparam logic signed [CNT_W-1:0] CNT_MIN = {1'b1, {(CNT_W-1){1'b0}}};

    typedef struct packed {
        logic                    present;
        logic signed [CNT_W-1:0] count;
    } t_entry;

    typedef struct packed {
        logic capture;
        logic clr_start;
        logic clr_step;
        logic acc_read;
        logic acc_write;
        logic find_start;
        logic find_issue;
        logic keep_res;
        logic load_out;
    } t_dp_cmd;

    typedef struct packed {
        logic clr_last;
        logic addr_ok;
        logic find_hit;
        logic out_free;
    } t_dp_sts;

endpackage

`default_nettype wire

// ===== rtl/vrra_in_if.sv =====
`default_nettype none

interface vrra_in_if;
    logic                        valid;
    logic                        ready;
    logic [vrra_pkg::CMD_W-1:0]  cmd;
    logic [vrra_pkg::VIEW_W-1:0] view;
    logic [vrra_pkg::ROW_W-1:0]  row;

    modport source (output valid, output cmd, output view, output row, input ready);
    modport sink (input valid, input cmd, input view, input row, output ready);
endinterface

`default_nettype wire

// ===== rtl/vrra_out_if.sv =====
`default_nettype none

interface vrra_out_if;
    logic                       valid;
    logic                       ready;
    logic [vrra_pkg::ROW_W-1:0] free_row;

    modport source (output valid, output free_row, input ready);
    modport sink (input valid, input free_row, output ready);
endinterface

`default_nettype wire

// ===== rtl/vrra_ctrl.sv =====
`default_nettype none

module vrra_ctrl (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_in_valid,
    input  vrra_pkg::t_cmd     i_in_cmd,
    output logic               o_in_ready,
    input  vrra_pkg::t_dp_sts  i_sts,
    output vrra_pkg::t_dp_cmd  o_cmd
);
    import vrra_pkg::*;

    typedef enum logic [2:0] {
        S_CLR,
        S_IDLE,
        S_ACC_RD,
        S_ACC_WR,
        S_FIND,
        S_RES
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        unique case (r_state)
            S_CLR: begin
                o_cmd.clr_step = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    unique case (i_in_cmd)
                        CMD_CLEAR: begin
                            o_cmd.clr_start = 1'b1;
                            n_state         = S_CLR;
                        end
                        CMD_FIND: begin
                            o_cmd.find_start = 1'b1;
                            n_state          = S_FIND;
                        end
                        CMD_OCCUPY, CMD_FREE: begin
                            n_state = S_ACC_RD;
                        end
                    endcase
                end
            end
            S_ACC_RD: begin
                if (i_sts.addr_ok) begin
                    o_cmd.acc_read = 1'b1;
                    n_state        = S_ACC_WR;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_ACC_WR: begin
                o_cmd.acc_write = 1'b1;
                n_state         = S_IDLE;
            end
            S_FIND: begin
                o_cmd.find_issue = 1'b1;
                if (i_sts.find_hit) begin
                    o_cmd.keep_res = 1'b1;
                    n_state        = S_RES;
                end
            end
            S_RES: begin
                if (i_sts.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
        end else begin
            r_state <= n_state;
        end
    end

    a_hit_to_res: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIND && i_sts.find_hit) |=> (r_state == S_RES))
        else $error("Search hit did not move to the result state.");

    a_find_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_in_ready && i_in_valid && i_in_cmd == CMD_FIND) |=> (r_state == S_FIND))
        else $error("Accepted search did not start the row walk.");

endmodule

`default_nettype wire

// ===== rtl/vrra_dp.sv =====
`default_nettype none

module vrra_dp #(
    parameter int NUM_VIEWS    = 16,
    parameter int NUM_ROWS     = 128,
    parameter int SEARCH_LIMIT = 100
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  vrra_pkg::t_cmd                   i_in_cmd,
    input  wire [vrra_pkg::VIEW_W-1:0]       i_in_view,
    input  wire [vrra_pkg::ROW_W-1:0]        i_in_row,
    input  vrra_pkg::t_dp_cmd                i_cmd,
    output vrra_pkg::t_dp_sts                o_sts,
    output logic                             o_out_valid,
    output logic [vrra_pkg::ROW_W-1:0]       o_out_free_row,
    input  wire                              i_out_ready
);
    import vrra_pkg::*;

    localparam int DEPTH = NUM_VIEWS * NUM_ROWS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int SW    = $clog2(SEARCH_LIMIT + 1);

    t_entry mem [DEPTH];

    t_cmd              r_op;
    logic [VIEW_W-1:0] r_view;
    logic [ROW_W-1:0]  r_row;
    logic [AW-1:0]     r_clr_addr;
    logic [SW-1:0]     r_rd;
    logic [SW-1:0]     r_pend_row;
    logic              r_pend_vld;
    logic              r_pend_force;
    t_entry            r_rdata;
    logic [ROW_W-1:0]  r_res;
    logic              r_out_vld;
    logic [ROW_W-1:0]  r_out_row;

    logic              view_ok;
    logic              find_force;
    logic              rd_more;
    logic [AW-1:0]     acc_addr;
    logic [AW-1:0]     find_addr;
    logic              mem_re;
    logic [AW-1:0]     mem_raddr;
    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    t_entry            mem_wdata;
    t_entry            upd;
    logic              pend_free;
    logic              hit;
    logic [ROW_W-1:0]  hit_row;

    assign view_ok    = 32'(r_view) < 32'(NUM_VIEWS);
    assign find_force = !view_ok || (32'(r_rd) >= 32'(NUM_ROWS));
    assign rd_more    = 32'(r_rd) < 32'(SEARCH_LIMIT);
    assign acc_addr   = AW'(32'(r_view) * 32'(NUM_ROWS) + 32'(r_row));
    assign find_addr  = AW'(32'(r_view) * 32'(NUM_ROWS) + 32'(r_rd));

    assign mem_re    = i_cmd.acc_read || (i_cmd.find_issue && rd_more && !find_force);
    assign mem_raddr = i_cmd.acc_read ? acc_addr : find_addr;
    assign mem_we    = i_cmd.clr_step || i_cmd.acc_write;
    assign mem_waddr = i_cmd.clr_step ? r_clr_addr : acc_addr;
    assign mem_wdata = i_cmd.clr_step ? t_entry'('0) : upd;

    always_comb begin
        upd = r_rdata;
        if (r_op == CMD_OCCUPY) begin
            if (!r_rdata.present) begin
                upd.present = 1'b1;
                upd.count   = CNT_W'(1);
            end else if (r_rdata.count != CNT_MAX) begin
                upd.count = r_rdata.count + CNT_W'(1);
            end
        end else begin
            if (r_rdata.present && r_rdata.count != CNT_MIN) begin
                upd.count = r_rdata.count - CNT_W'(1);
            end
        end
    end

    assign pend_free = r_pend_force || !r_rdata.present || (r_rdata.count == '0);
    assign hit       = r_pend_vld
                       && (pend_free || (32'(r_pend_row) == 32'(SEARCH_LIMIT - 1)));
    assign hit_row   = pend_free ? ROW_W'(r_pend_row) : ROW_W'(SEARCH_LIMIT);

    assign o_sts.clr_last = (r_clr_addr == AW'(DEPTH - 1));
    assign o_sts.addr_ok  = view_ok && (32'(r_row) < 32'(NUM_ROWS));
    assign o_sts.find_hit = hit;
    assign o_sts.out_free = !r_out_vld || i_out_ready;

    assign o_out_valid    = r_out_vld;
    assign o_out_free_row = r_out_row;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rdata <= mem[mem_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op   <= i_in_cmd;
            r_view <= i_in_view;
            r_row  <= i_in_row;
        end
        if (i_cmd.find_issue) begin
            r_pend_row   <= r_rd;
            r_pend_force <= find_force;
        end
        if (i_cmd.keep_res) begin
            r_res <= hit_row;
        end
        if (i_cmd.load_out) begin
            r_out_row <= r_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
            r_rd       <= '0;
            r_pend_vld <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            if (i_cmd.clr_start) begin
                r_clr_addr <= '0;
            end else if (i_cmd.clr_step) begin
                r_clr_addr <= r_clr_addr + AW'(1);
            end
            if (i_cmd.find_start) begin
                r_rd       <= '0;
                r_pend_vld <= 1'b0;
            end else if (i_cmd.find_issue) begin
                r_pend_vld <= rd_more;
                if (rd_more) begin
                    r_rd <= r_rd + SW'(1);
                end
            end
            if (i_cmd.load_out) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    a_one_mem_user: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({i_cmd.clr_step, i_cmd.acc_read, i_cmd.acc_write, i_cmd.find_issue}))
        else $error("More than one operation drove the table in one cycle.");

    a_load_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load_out |-> (!r_out_vld || i_out_ready))
        else $error("Result register overwritten before its transfer.");

    a_walk_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.find_start |=> (!r_pend_vld && r_rd == '0))
        else $error("Row walk did not restart from the first row.");

endmodule

`default_nettype wire

// ===== rtl/view_row_refcount_allocator_unit.sv =====
// Row allocator keeping a signed 16-bit reference count and a present mark for
// every row of every view, held in one on-chip table of NUM_VIEWS * NUM_ROWS words.
// Commands arrive on the i_in channel (cmd, view, row); a transfer takes place
// when valid and ready are both high. Occupy and free give no result; after the
// transfer they do a table read and a write back if the view and row are in range.
// Find walks the rows of the view from row zero, one row per cycle through the
// table's read port, and returns the lowest free row or SEARCH_LIMIT on the o_out
// channel; the result goes through a result register into the output register.
// Clear, and also reset, runs a clearing pass that writes every table word, one per
// cycle; no command is taken during the pass.
// A finished result sits in an output register; the block takes the next command
// while it waits. If the receiver stalls and a second find result is ready, the
// block holds it and takes no new command until the register is free again.
`default_nettype none

module view_row_refcount_allocator_unit #(
    parameter int NUM_VIEWS    = 16,
    parameter int NUM_ROWS     = 128,
    parameter int SEARCH_LIMIT = 100
) (
    input  wire          i_clk,
    input  wire          i_rst_n,
    vrra_in_if.sink      i_in,
    vrra_out_if.source   o_out
);
    import vrra_pkg::*;

    t_dp_cmd dp_cmd;
    t_dp_sts dp_sts;
    logic    in_ready;

    assign i_in.ready = in_ready;

    vrra_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_in_cmd   (t_cmd'(i_in.cmd)),
        .o_in_ready (in_ready),
        .i_sts      (dp_sts),
        .o_cmd      (dp_cmd)
    );

    vrra_dp #(
        .NUM_VIEWS    (NUM_VIEWS),
        .NUM_ROWS     (NUM_ROWS),
        .SEARCH_LIMIT (SEARCH_LIMIT)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_cmd       (t_cmd'(i_in.cmd)),
        .i_in_view      (i_in.view),
        .i_in_row       (i_in.row),
        .i_cmd          (dp_cmd),
        .o_sts          (dp_sts),
        .o_out_valid    (o_out.valid),
        .o_out_free_row (o_out.free_row),
        .i_out_ready    (o_out.ready)
    );

endmodule

`default_nettype wire
